FILE: hdl/bcdcal_pkg.sv
// ----------------------------------------------------------------------------
// bcdcal_pkg: shared types and helpers for the BCD calendar rollover
// Payload structs, calendar constants and BCD decode / encode / month length.
// ----------------------------------------------------------------------------
package bcdcal_pkg;

    typedef struct packed {
        logic [7:0] hour_code;
        logic [7:0] weekday_code;
        logic [7:0] day_code;
        logic [7:0] month_code;
        logic [7:0] year_code;
    } bcdcal_in_t;

    typedef struct packed {
        logic [7:0] hour_out;
        logic [7:0] weekday_out;
        logic [7:0] day_out;
        logic [7:0] month_out;
        logic [7:0] year_out;
        logic       rolled_over;
    } bcdcal_out_t;

    localparam logic [7:0] HOUR_MAX      = 8'd23;
    localparam logic [7:0] WDAY_MAX      = 8'd7;
    localparam logic [7:0] MONTH_MAX     = 8'd12;
    localparam logic [7:0] YEAR_MAX      = 8'd99;
    // 2100 is the only non-leap century year reachable from 2000 + 0..165
    localparam logic [7:0] YEAR_NONLEAP  = 8'd100;
    localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
    localparam logic [4:0] LONG_MONTH    = 5'd31;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // low nibble + 10 * high nibble, 0..165
    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    // tens via reciprocal multiply (exact below 1029), tens digit wraps to 4 bits
    function automatic logic [7:0] bcd_encode(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  tens;
        logic [7:0]  ones;
        prod = 16'(v) * 16'd205;
        tens = prod[15:11];
        ones = v - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
        return {tens[3:0], ones[3:0]};
    endfunction

    function automatic logic [4:0] days_in(input logic [7:0] month,
                                           input logic [7:0] year);
        logic       leap;
        logic [3:0] idx;
        leap = (year[1:0] == 2'b00) && (year != YEAR_NONLEAP);
        idx  = 4'(month - 8'd1);
        if (!(month inside {[8'd1:MONTH_MAX]})) begin
            return LONG_MONTH;
        end else if (month == 8'd2 && leap) begin
            return FEB_LEAP_DAYS;
        end else begin
            return MONTH_LEN[idx];
        end
    endfunction

endpackage

FILE: hdl/bcdcal_advance.sv
// ----------------------------------------------------------------------------
// bcdcal_advance: combinational hour check and date advance
// Decodes the snapshot, advances weekday/day/month/year on hour overflow.
// ----------------------------------------------------------------------------
module bcdcal_advance
    import bcdcal_pkg::*;
(
    input  bcdcal_in_t  snap,
    output bcdcal_out_t result
);

    logic [7:0] hour, wday, day, month, year;
    logic [7:0] wday_inc, day_inc, month_inc, year_inc;
    logic [7:0] wday_new, day_new, month_new, year_new;
    logic [4:0] limit;
    logic       roll, day_ovf, month_ovf;

    always_comb begin
        hour  = bcd_decode(snap.hour_code);
        wday  = bcd_decode(snap.weekday_code);
        day   = bcd_decode(snap.day_code);
        month = bcd_decode(snap.month_code);
        year  = bcd_decode(snap.year_code);
        roll  = hour > HOUR_MAX;
        limit = days_in(month, year);

        wday_inc = wday + 8'd1;
        wday_new = (wday_inc > WDAY_MAX) ? 8'd1 : wday_inc;

        day_inc = day + 8'd1;
        day_ovf = day_inc > {3'd0, limit};
        day_new = day_ovf ? 8'd1 : day_inc;

        month_inc = month + 8'd1;
        month_ovf = day_ovf && (month_inc > MONTH_MAX);
        if (!day_ovf) begin
            month_new = month;
        end else if (month_ovf) begin
            month_new = 8'd1;
        end else begin
            month_new = month_inc;
        end

        year_inc = year + 8'd1;
        if (!month_ovf) begin
            year_new = year;
        end else if (year >= YEAR_MAX) begin
            year_new = 8'd0;
        end else begin
            year_new = year_inc;
        end

        if (roll) begin
            result.hour_out    = 8'd0;
            result.weekday_out = bcd_encode(wday_new);
            result.day_out     = bcd_encode(day_new);
            result.month_out   = bcd_encode(month_new);
            result.year_out    = bcd_encode(year_new);
            result.rolled_over = 1'b1;
        end else begin
            result.hour_out    = snap.hour_code;
            result.weekday_out = snap.weekday_code;
            result.day_out     = snap.day_code;
            result.month_out   = snap.month_code;
            result.year_out    = snap.year_code;
            result.rolled_over = 1'b0;
        end
    end

endmodule

FILE: hdl/bcd_calendar_day_rollover.sv
// ----------------------------------------------------------------------------
// bcd_calendar_day_rollover: BCD calendar snapshot rollover correction
// Checks an RTC hour byte for overflow and advances the calendar date.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one calendar snapshot (hour, weekday, day, month, year bytes,
//   all BCD) per transfer on s_valid/s_ready, packed in s_data.
//   m_ channel: one corrected snapshot per input transfer on m_valid/m_ready,
//   with rolled_over set when the hour was above 23 and the date advanced.
//   Path: each input transfer is captured in the input register, then in the
//   result register, which drives m_valid. Throughput: one transfer per cycle
//   while the receiver keeps m_ready high; the date logic between the two
//   registers is a single short pass (BCD decode, month length lookup,
//   increments and a reciprocal-multiply re-encode).
//   Reset (aresetn low, synchronous) empties both stages; no results pending.
//   Stall: while m_ready is low the result register holds. The input stage
//   still takes one more transfer if it is empty, then s_ready drops until
//   the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module bcd_calendar_day_rollover
    import bcdcal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  bcdcal_in_t  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output bcdcal_out_t m_data
);

    logic        in_valid_reg;
    bcdcal_in_t  in_data_reg;
    logic        out_valid_reg;
    bcdcal_out_t out_data_reg;
    bcdcal_out_t result_next;
    logic        advance;

    // result stage can load when empty or its content leaves this cycle
    assign advance = !out_valid_reg || m_ready;
    // input stage can load when empty or its content moves on
    assign s_ready = !in_valid_reg || advance;

    bcdcal_advance u_advance (
        .snap   (in_data_reg),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && in_valid_reg) begin
            out_data_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: tb/bcdcal_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bcdcal_checker: scoreboard for the BCD calendar rollover block
// Watches both channels, computes the corrected snapshot for every input
// transfer and compares each output transfer against the oldest one.
// ----------------------------------------------------------------------------
module bcdcal_checker
    import bcdcal_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  bcdcal_in_t  s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  bcdcal_out_t m_data,
    output int          mismatches,
    output int          outstanding
);

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};
    localparam int unsigned LEAP_FEB   = 29;
    localparam int unsigned ODD_MONTH  = 31;
    localparam int unsigned BASE_YEAR  = 2000;
    localparam int          MAX_REPORT = 10;

    bcdcal_out_t corrected_q[$];
    bcdcal_out_t oldest;
    int          fail_count = 0;

    function automatic int unsigned bcd_value(input logic [7:0] b);
        return int'(b[3:0]) + 10 * int'(b[7:4]);
    endfunction

    // non-BCD values wrap: the tens digit keeps only its low nibble
    function automatic logic [7:0] bcd_byte(input int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic int unsigned month_length(input int unsigned mon,
                                                 input int unsigned yr);
        int unsigned full;
        full = BASE_YEAR + yr;
        if (mon < 1 || mon > MONTH_MAX) begin
            return ODD_MONTH;
        end
        if (mon == 2 && full % 4 == 0 && !(full % 100 == 0 && full % 400 != 0)) begin
            return LEAP_FEB;
        end
        return MONTH_DAYS[mon - 1];
    endfunction

    function automatic bcdcal_out_t roll_date(input bcdcal_in_t snap);
        bcdcal_out_t res;
        int unsigned wd, dy, mo, yr, mlen;
        if (bcd_value(snap.hour_code) <= HOUR_MAX) begin
            res = '{snap.hour_code, snap.weekday_code, snap.day_code,
                    snap.month_code, snap.year_code, 1'b0};
            return res;
        end
        wd   = bcd_value(snap.weekday_code) + 1;
        dy   = bcd_value(snap.day_code) + 1;
        mo   = bcd_value(snap.month_code);
        yr   = bcd_value(snap.year_code);
        mlen = month_length(mo, yr);
        if (wd > WDAY_MAX) begin
            wd = 1;
        end
        if (dy > mlen) begin
            dy = 1;
            mo = mo + 1;
            if (mo > MONTH_MAX) begin
                mo = 1;
                yr = (yr >= YEAR_MAX) ? 0 : yr + 1;
            end
        end
        res = '{8'h00, bcd_byte(wd), bcd_byte(dy), bcd_byte(mo), bcd_byte(yr), 1'b1};
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORT) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name,
                         want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            corrected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (corrected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORT) begin
                        $display("%0t: output transfer %h with nothing expected",
                                 $realtime, m_data);
                    end
                end else begin
                    oldest = corrected_q.pop_front();
                    compare_field("hour_out",    oldest.hour_out,    m_data.hour_out);
                    compare_field("weekday_out", oldest.weekday_out, m_data.weekday_out);
                    compare_field("day_out",     oldest.day_out,     m_data.day_out);
                    compare_field("month_out",   oldest.month_out,   m_data.month_out);
                    compare_field("year_out",    oldest.year_out,    m_data.year_out);
                    compare_field("rolled_over", {7'd0, oldest.rolled_over},
                                  {7'd0, m_data.rolled_over});
                end
            end
            if (s_valid && s_ready) begin
                corrected_q.push_back(roll_date(s_data));
            end
        end
        outstanding <= corrected_q.size();
        mismatches  <= fail_count;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the BCD calendar rollover block
// Drives calendar snapshots (directed corner dates, then random ones) under
// several handshake idle/stall mixes; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench
    import bcdcal_pkg::*;
();

    localparam int RANDOM_PER_PHASE = 240;
    localparam int PHASE_COUNT      = 4;
    localparam int SETTLE_CYCLES    = 8;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    bcdcal_in_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    bcdcal_out_t m_data;

    int mismatches;
    int outstanding;

    // percent of cycles the sender sits idle / the receiver stalls
    int gap_pct   = 0;
    int stall_pct = 0;

    bcd_calendar_day_rollover dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    bcdcal_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Mostly plausible dates with hours around the rollover point and days
    // near month end, so carries into month and year happen often; the rest
    // is raw bytes (non-BCD digits, months and weekdays out of range).
    function automatic bcdcal_in_t random_snapshot();
        bcdcal_in_t snap;
        if ($urandom_range(99) < 65) begin
            snap.hour_code    = to_bcd($urandom_range(3) == 0 ? $urandom_range(23)
                                                              : $urandom_range(24, 39));
            snap.weekday_code = to_bcd($urandom_range(1, 7));
            snap.day_code     = to_bcd($urandom_range(1) ? $urandom_range(26, 31)
                                                         : $urandom_range(1, 31));
            snap.month_code   = to_bcd($urandom_range(1, 12));
            snap.year_code    = to_bcd($urandom_range(99));
        end else begin
            snap = bcdcal_in_t'({$urandom, 8'($urandom)});
        end
        return snap;
    endfunction

    // One transfer. Optional idle cycles first, then valid stays up until
    // the handshake; valid is not dropped between back-to-back transfers.
    task automatic send_snapshot(input bcdcal_in_t snap);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= snap;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    // Sender goes quiet until every predicted result has been taken.
    // The first edge lets the checker count the last transfer.
    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (outstanding != 0);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed: corner dates, no idling ----
        send_snapshot(bcdcal_in_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_snapshot(bcdcal_in_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        // hour 23 passes through, hour 24 rolls New Year's Eve into 2000
        send_snapshot(bcdcal_in_t'{8'h23, 8'h07, 8'h31, 8'h12, 8'h99});
        send_snapshot(bcdcal_in_t'{8'h24, 8'h07, 8'h31, 8'h12, 8'h99});
        send_snapshot(bcdcal_in_t'{8'hFF, 8'h00, 8'h15, 8'h06, 8'h20});
        // non-BCD digits get re-encoded on rollover
        send_snapshot(bcdcal_in_t'{8'h2A, 8'hFF, 8'h1A, 8'h1A, 8'h05});
        send_snapshot(bcdcal_in_t'{8'h0F, 8'h0A, 8'h0B, 8'h0C, 8'h0D});
        send_snapshot(bcdcal_in_t'{8'h1F, 8'h0F, 8'h09, 8'h09, 8'h09});
        // February in common, leap and century years (2000 leap, 2100 not)
        send_snapshot(bcdcal_in_t'{8'h25, 8'h03, 8'h28, 8'h02, 8'h01});
        send_snapshot(bcdcal_in_t'{8'h25, 8'h03, 8'h28, 8'h02, 8'h04});
        send_snapshot(bcdcal_in_t'{8'h25, 8'h03, 8'h29, 8'h02, 8'h24});
        send_snapshot(bcdcal_in_t'{8'h30, 8'h04, 8'h28, 8'h02, 8'h00});
        send_snapshot(bcdcal_in_t'{8'h30, 8'h04, 8'h28, 8'h02, 8'hA0});
        send_snapshot(bcdcal_in_t'{8'h30, 8'h05, 8'h28, 8'h02, 8'h96});
        // 30- and 31-day month ends
        send_snapshot(bcdcal_in_t'{8'h24, 8'h02, 8'h30, 8'h04, 8'h10});
        send_snapshot(bcdcal_in_t'{8'h24, 8'h02, 8'h31, 8'h01, 8'h10});
        send_snapshot(bcdcal_in_t'{8'h24, 8'h06, 8'h31, 8'h12, 8'h98});
        // months outside 1..12 count as 31 days
        send_snapshot(bcdcal_in_t'{8'h24, 8'h01, 8'h30, 8'h00, 8'h10});
        send_snapshot(bcdcal_in_t'{8'h24, 8'h01, 8'h31, 8'h00, 8'h10});
        send_snapshot(bcdcal_in_t'{8'h24, 8'h01, 8'h31, 8'h13, 8'h99});
        // year above 99 wraps to zero, oversized day always overflows
        send_snapshot(bcdcal_in_t'{8'h24, 8'h01, 8'h31, 8'hFF, 8'hFF});
        send_snapshot(bcdcal_in_t'{8'h24, 8'h01, 8'h99, 8'h06, 8'h50});
        drain_results();

        // ---- random: idle mixes, with a full drain between them ----
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 78; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 78; end
                default: begin gap_pct = 22; stall_pct = 22; end
            endcase
            repeat (RANDOM_PER_PHASE) send_snapshot(random_snapshot());
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/bcdcal_pkg.sv
hdl/bcdcal_advance.sv
hdl/bcd_calendar_day_rollover.sv
tb/bcdcal_checker.sv
tb/testbench.sv
